### hw/rtl/prdt_pkg.sv
// Shared types, register indexes and reset values for the pulse-distance
// remote transmitter. No dependencies.
package prdt_pkg;

    localparam int US_PER_MS_DEF     = 1000;
    localparam int BITS_PER_BYTE_DEF = 8;

    localparam int CFG_IDX_W = 3;
    localparam int LEN_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MARK        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPACE_ZERO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPACE_ONE   = 3'd4;

    localparam logic [LEN_W-1:0] HEADER_LOW_RST  = 16'd6000;
    localparam logic [LEN_W-1:0] HEADER_HIGH_RST = 16'd3000;
    localparam logic [LEN_W-1:0] MARK_RST        = 16'd400;
    localparam logic [LEN_W-1:0] SPACE_ZERO_RST  = 16'd400;
    localparam logic [LEN_W-1:0] SPACE_ONE_RST   = 16'd1200;

    typedef struct packed {
        logic [LEN_W-1:0] header_low_us;
        logic [LEN_W-1:0] header_high_us;
        logic [LEN_W-1:0] mark_us;
        logic [LEN_W-1:0] space_zero_us;
        logic [LEN_W-1:0] space_one_us;
    } prdt_cfg_t;

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_HDR_LOW  = 6'b000010,
        PH_HDR_HIGH = 6'b000100,
        PH_MARK     = 6'b001000,
        PH_SPACE    = 6'b010000,
        PH_HOLD     = 6'b100000
    } prdt_phase_t;

    // A programmed length of zero lasts one tick.
    function automatic logic [LEN_W-1:0] len_of(input logic [LEN_W-1:0] v);
        return (v == '0) ? LEN_W'(1) : v;
    endfunction

endpackage

### hw/rtl/prdt_cfg_regs.sv
// Timing register file for the pulse-distance remote transmitter.
// Depends on prdt_pkg for the register indexes, reset values and struct.
module prdt_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [prdt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [prdt_pkg::LEN_W-1:0]         cfg_data,
    output prdt_pkg::prdt_cfg_t                cfg
);

    prdt_pkg::prdt_cfg_t cfg_reg;
    prdt_pkg::prdt_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                prdt_pkg::REG_HEADER_LOW:  cfg_next.header_low_us  = cfg_data;
                prdt_pkg::REG_HEADER_HIGH: cfg_next.header_high_us = cfg_data;
                prdt_pkg::REG_MARK:        cfg_next.mark_us        = cfg_data;
                prdt_pkg::REG_SPACE_ZERO:  cfg_next.space_zero_us  = cfg_data;
                prdt_pkg::REG_SPACE_ONE:   cfg_next.space_one_us   = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_low_us  <= prdt_pkg::HEADER_LOW_RST;
            cfg_reg.header_high_us <= prdt_pkg::HEADER_HIGH_RST;
            cfg_reg.mark_us        <= prdt_pkg::MARK_RST;
            cfg_reg.space_zero_us  <= prdt_pkg::SPACE_ZERO_RST;
            cfg_reg.space_one_us   <= prdt_pkg::SPACE_ONE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hw/rtl/prdt_core.sv
// Waveform sequencer: phase, tick, bit and hold counters updated once per item.
// Depends on prdt_pkg for the phase enum, config struct and len_of.
module prdt_core #(
    parameter int US_PER_MS     = prdt_pkg::US_PER_MS_DEF,
    parameter int BITS_PER_BYTE = prdt_pkg::BITS_PER_BYTE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          kind,
    input  logic [7:0]                    first_byte,
    input  logic [7:0]                    second_byte,
    input  logic [prdt_pkg::LEN_W-1:0]    hold_ms,
    input  prdt_pkg::prdt_cfg_t           cfg,
    output logic                          line_next,
    output logic                          busy_next,
    output logic                          rejected_next
);

    localparam int FRAME_W = 2 * BITS_PER_BYTE;
    localparam int CNT_W   = $clog2(FRAME_W + 1);
    localparam int PSC_W   = (US_PER_MS > 1) ? $clog2(US_PER_MS) : 1;

    prdt_pkg::prdt_phase_t          phase_reg, phase_next;
    logic [prdt_pkg::LEN_W-1:0]     ticks_reg, ticks_next;
    logic [PSC_W-1:0]               psc_reg, psc_next;
    logic [CNT_W-1:0]               bit_cnt_reg, bit_cnt_next;
    logic [FRAME_W-1:0]             frame_reg, frame_next;
    logic [prdt_pkg::LEN_W-1:0]     hold_left_reg, hold_left_next;
    logic [prdt_pkg::LEN_W-1:0]     hold_len_reg, hold_len_next;

    logic [FRAME_W-1:0]             frame_load;
    logic [31:0]                    first_ext;
    logic [31:0]                    second_ext;
    logic [CNT_W-1:0]               bit_cnt_inc;
    logic                           last_tick;

    assign first_ext  = {24'd0, first_byte};
    assign second_ext = {24'd0, second_byte};

    // Bits above the byte width are never sent.
    always_comb
    begin
        for (int i = 0; i < BITS_PER_BYTE; i++)
        begin
            frame_load[i]                 = first_ext[i];
            frame_load[BITS_PER_BYTE + i] = second_ext[i];
        end
    end

    assign bit_cnt_inc = bit_cnt_reg + CNT_W'(1);
    assign last_tick   = (ticks_reg == prdt_pkg::LEN_W'(1));

    always_comb
    begin
        phase_next     = phase_reg;
        ticks_next     = ticks_reg;
        psc_next       = psc_reg;
        bit_cnt_next   = bit_cnt_reg;
        frame_next     = frame_reg;
        hold_left_next = hold_left_reg;
        hold_len_next  = hold_len_reg;
        rejected_next  = 1'b0;

        if (kind)
        begin
            if (phase_reg != prdt_pkg::PH_IDLE)
            begin
                rejected_next = 1'b1;
            end
            else
            begin
                frame_next     = frame_load;
                hold_len_next  = hold_ms;
                bit_cnt_next   = '0;
                psc_next       = '0;
                hold_left_next = '0;
                phase_next     = prdt_pkg::PH_HDR_LOW;
                ticks_next     = prdt_pkg::len_of(cfg.header_low_us);
            end
        end
        else
        begin
            case (phase_reg)
                prdt_pkg::PH_IDLE:
                begin
                    phase_next = prdt_pkg::PH_IDLE;
                end
                prdt_pkg::PH_HDR_LOW:
                begin
                    ticks_next = ticks_reg - prdt_pkg::LEN_W'(1);
                    if (last_tick)
                    begin
                        phase_next = prdt_pkg::PH_HDR_HIGH;
                        ticks_next = prdt_pkg::len_of(cfg.header_high_us);
                    end
                end
                prdt_pkg::PH_HDR_HIGH:
                begin
                    ticks_next = ticks_reg - prdt_pkg::LEN_W'(1);
                    if (last_tick)
                    begin
                        phase_next   = prdt_pkg::PH_MARK;
                        bit_cnt_next = '0;
                        ticks_next   = prdt_pkg::len_of(cfg.mark_us);
                    end
                end
                prdt_pkg::PH_MARK:
                begin
                    ticks_next = ticks_reg - prdt_pkg::LEN_W'(1);
                    if (last_tick)
                    begin
                        // The current bit always sits at the bottom of the frame.
                        phase_next = prdt_pkg::PH_SPACE;
                        ticks_next = prdt_pkg::len_of(frame_reg[0] ? cfg.space_one_us
                                                                   : cfg.space_zero_us);
                    end
                end
                prdt_pkg::PH_SPACE:
                begin
                    ticks_next = ticks_reg - prdt_pkg::LEN_W'(1);
                    if (last_tick)
                    begin
                        bit_cnt_next = bit_cnt_inc;
                        frame_next   = frame_reg >> 1;
                        if (bit_cnt_inc < CNT_W'(FRAME_W))
                        begin
                            phase_next = prdt_pkg::PH_MARK;
                            ticks_next = prdt_pkg::len_of(cfg.mark_us);
                        end
                        else if (hold_len_reg == '0)
                        begin
                            phase_next = prdt_pkg::PH_IDLE;
                        end
                        else
                        begin
                            phase_next     = prdt_pkg::PH_HOLD;
                            hold_left_next = hold_len_reg;
                            psc_next       = '0;
                        end
                    end
                end
                prdt_pkg::PH_HOLD:
                begin
                    psc_next = psc_reg + PSC_W'(1);
                    if (psc_reg == PSC_W'(US_PER_MS - 1))
                    begin
                        psc_next       = '0;
                        hold_left_next = hold_left_reg - prdt_pkg::LEN_W'(1);
                        if (hold_left_reg == prdt_pkg::LEN_W'(1))
                        begin
                            phase_next = prdt_pkg::PH_IDLE;
                        end
                    end
                end
                default:
                begin
                    phase_next = prdt_pkg::PH_IDLE;
                end
            endcase
        end
    end

    assign line_next = (phase_next == prdt_pkg::PH_IDLE) ||
                       (phase_next == prdt_pkg::PH_HDR_HIGH) ||
                       (phase_next == prdt_pkg::PH_SPACE);
    assign busy_next = (phase_next != prdt_pkg::PH_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= prdt_pkg::PH_IDLE;
            ticks_reg     <= '0;
            psc_reg       <= '0;
            bit_cnt_reg   <= '0;
            frame_reg     <= '0;
            hold_left_reg <= '0;
            hold_len_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            ticks_reg     <= ticks_next;
            psc_reg       <= psc_next;
            bit_cnt_reg   <= bit_cnt_next;
            frame_reg     <= frame_next;
            hold_left_reg <= hold_left_next;
            hold_len_reg  <= hold_len_next;
        end
    end

    // Counting phases never sit at a zero count.
    a_ticks_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == prdt_pkg::PH_HDR_LOW || phase_reg == prdt_pkg::PH_HDR_HIGH ||
         phase_reg == prdt_pkg::PH_MARK || phase_reg == prdt_pkg::PH_SPACE)
        |-> ticks_reg != '0)
        else $error("tick counter is zero in a counting phase");

    a_hold_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == prdt_pkg::PH_HOLD |-> hold_left_reg != '0)
        else $error("hold phase with no milliseconds left");

    a_start_taken: assert property (@(posedge clk) disable iff (!rst_n)
        step && kind && phase_reg == prdt_pkg::PH_IDLE |=> phase_reg == prdt_pkg::PH_HDR_LOW)
        else $error("start while idle did not open a frame");

    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        step && kind && phase_reg != prdt_pkg::PH_IDLE |=> $stable(phase_reg))
        else $error("rejected start disturbed the frame");

endmodule

### hw/rtl/pulse_distance_remote_transmitter.sv
// Top level of the pulse-distance remote transmitter: input stage, result stage.
// Depends on prdt_pkg, prdt_cfg_regs and prdt_core.
//
//  channel  signals                                        direction
//  in       in_valid/in_ready, kind, first_byte,           to block
//           second_byte, hold_ms
//  out      out_valid/out_ready, line_level, busy_res,     from block
//           start_rejected
//  cfg      cfg_valid/cfg_ready, cfg_index, cfg_data       to block
//
// One item per cycle sustained while the result is not stalled; each accepted item
// passes the input register, then the sequencer update into the result register.
// The sequencer counters take one step per item.
// After reset the sequencer is idle and the timing registers hold their defaults.
// A stalled result holds the result register; the input register keeps accepting
// until it, too, holds an item. cfg_ready is always high.
module pulse_distance_remote_transmitter #(
    parameter int US_PER_MS     = prdt_pkg::US_PER_MS_DEF,
    parameter int BITS_PER_BYTE = prdt_pkg::BITS_PER_BYTE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              kind,
    input  logic [7:0]                        first_byte,
    input  logic [7:0]                        second_byte,
    input  logic [prdt_pkg::LEN_W-1:0]        hold_ms,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              line_level,
    output logic                              busy_res,
    output logic                              start_rejected,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [prdt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [prdt_pkg::LEN_W-1:0]        cfg_data
);

    prdt_pkg::prdt_cfg_t             cfg;

    logic                            stage_vld_reg;
    logic                            kind_reg;
    logic [7:0]                      first_reg;
    logic [7:0]                      second_reg;
    logic [prdt_pkg::LEN_W-1:0]      hold_reg;

    logic                            out_vld_reg;
    logic                            line_reg;
    logic                            busy_reg;
    logic                            rej_reg;

    logic                            stage_go;
    logic                            line_next;
    logic                            busy_next;
    logic                            rejected_next;

    prdt_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    prdt_core #(
        .US_PER_MS     (US_PER_MS),
        .BITS_PER_BYTE (BITS_PER_BYTE)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (stage_go),
        .kind          (kind_reg),
        .first_byte    (first_reg),
        .second_byte   (second_reg),
        .hold_ms       (hold_reg),
        .cfg           (cfg),
        .line_next     (line_next),
        .busy_next     (busy_next),
        .rejected_next (rejected_next)
    );

    // Advance the staged item when the result register is free or being drained.
    assign stage_go = stage_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !stage_vld_reg || stage_go;

    assign out_valid      = out_vld_reg;
    assign line_level     = line_reg;
    assign busy_res       = busy_reg;
    assign start_rejected = rej_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                stage_vld_reg <= 1'b1;
            end
            else if (stage_go)
            begin
                stage_vld_reg <= 1'b0;
            end

            if (stage_go)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg   <= kind;
            first_reg  <= first_byte;
            second_reg <= second_byte;
            hold_reg   <= hold_ms;
        end
        if (stage_go)
        begin
            line_reg <= line_next;
            busy_reg <= busy_next;
            rej_reg  <= rejected_next;
        end
    end

endmodule

### tb/tb_pulse_distance_remote_transmitter.sv
// Self-checking testbench for the pulse-distance remote transmitter.
// Depends on prdt_pkg and pulse_distance_remote_transmitter; a scoreboard class
// predicts the line waveform per item, plain tasks drive the input and config channels.
module tb_pulse_distance_remote_transmitter;

    localparam int FRAME_BITS      = 2 * prdt_pkg::BITS_PER_BYTE_DEF;
    localparam int IDLE_LIMIT      = 4000;
    localparam int PRESSURE_CYCLES = 400;
    localparam int CALM_FIRST      = 400;
    localparam int CALM_LAST       = 700;

    typedef struct packed {
        logic line;
        logic busy;
        logic rejected;
    } line_sample_t;

    class tx_scoreboard;
        prdt_pkg::prdt_cfg_t    timing;
        prdt_pkg::prdt_phase_t  phase;
        logic [15:0]            ticks_left;
        logic [9:0]             ms_count;
        logic [4:0]             bit_pos;
        logic [15:0]            frame_bits;
        logic [15:0]            hold_left;
        logic [15:0]            hold_len;
        line_sample_t           expected_q[$];
        int                     mismatches;
        int                     checked;
        int                     frames_started;
        int                     starts_rejected;

        function new();
            timing.header_low_us  = prdt_pkg::HEADER_LOW_RST;
            timing.header_high_us = prdt_pkg::HEADER_HIGH_RST;
            timing.mark_us        = prdt_pkg::MARK_RST;
            timing.space_zero_us  = prdt_pkg::SPACE_ZERO_RST;
            timing.space_one_us   = prdt_pkg::SPACE_ONE_RST;
            phase           = prdt_pkg::PH_IDLE;
            ticks_left      = '0;
            ms_count        = '0;
            bit_pos         = '0;
            frame_bits      = '0;
            hold_left       = '0;
            hold_len        = '0;
            mismatches      = 0;
            checked         = 0;
            frames_started  = 0;
            starts_rejected = 0;
        endfunction

        function void set_reg(logic [prdt_pkg::CFG_IDX_W-1:0] idx,
                              logic [prdt_pkg::LEN_W-1:0] data);
            case (idx)
                prdt_pkg::REG_HEADER_LOW:  timing.header_low_us  = data;
                prdt_pkg::REG_HEADER_HIGH: timing.header_high_us = data;
                prdt_pkg::REG_MARK:        timing.mark_us        = data;
                prdt_pkg::REG_SPACE_ZERO:  timing.space_zero_us  = data;
                prdt_pkg::REG_SPACE_ONE:   timing.space_one_us   = data;
                default:                   ;
            endcase
        endfunction

        function bit frame_active();
            return phase != prdt_pkg::PH_IDLE;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // A zero length still lasts one tick.
        function logic [15:0] eff_len(logic [15:0] v);
            return (v == 16'd0) ? 16'd1 : v;
        endfunction

        function void step_tick();
            case (phase)
                prdt_pkg::PH_HDR_LOW:
                begin
                    ticks_left = ticks_left - 16'd1;
                    if (ticks_left == 16'd0)
                    begin
                        phase      = prdt_pkg::PH_HDR_HIGH;
                        ticks_left = eff_len(timing.header_high_us);
                    end
                end
                prdt_pkg::PH_HDR_HIGH:
                begin
                    ticks_left = ticks_left - 16'd1;
                    if (ticks_left == 16'd0)
                    begin
                        phase      = prdt_pkg::PH_MARK;
                        bit_pos    = '0;
                        ticks_left = eff_len(timing.mark_us);
                    end
                end
                prdt_pkg::PH_MARK:
                begin
                    ticks_left = ticks_left - 16'd1;
                    if (ticks_left == 16'd0)
                    begin
                        phase      = prdt_pkg::PH_SPACE;
                        ticks_left = eff_len(frame_bits[bit_pos[3:0]] ?
                                             timing.space_one_us : timing.space_zero_us);
                    end
                end
                prdt_pkg::PH_SPACE:
                begin
                    ticks_left = ticks_left - 16'd1;
                    if (ticks_left == 16'd0)
                    begin
                        bit_pos = bit_pos + 5'd1;
                        if (bit_pos < FRAME_BITS)
                        begin
                            phase      = prdt_pkg::PH_MARK;
                            ticks_left = eff_len(timing.mark_us);
                        end
                        else if (hold_len == 16'd0)
                        begin
                            phase = prdt_pkg::PH_IDLE;
                        end
                        else
                        begin
                            phase     = prdt_pkg::PH_HOLD;
                            hold_left = hold_len;
                            ms_count  = '0;
                        end
                    end
                end
                prdt_pkg::PH_HOLD:
                begin
                    ms_count = ms_count + 10'd1;
                    if (ms_count >= prdt_pkg::US_PER_MS_DEF)
                    begin
                        ms_count  = '0;
                        hold_left = hold_left - 16'd1;
                        if (hold_left == 16'd0)
                            phase = prdt_pkg::PH_IDLE;
                    end
                end
                default: phase = prdt_pkg::PH_IDLE;
            endcase
        endfunction

        function void note_item(logic k, logic [7:0] fb, logic [7:0] sb, logic [15:0] hm);
            line_sample_t s;
            s.rejected = 1'b0;
            if (k)
            begin
                if (phase != prdt_pkg::PH_IDLE)
                begin
                    // Refused start: the frame in progress is untouched.
                    s.rejected = 1'b1;
                    starts_rejected++;
                end
                else
                begin
                    frame_bits = {sb, fb};
                    hold_len   = hm;
                    bit_pos    = '0;
                    ms_count   = '0;
                    hold_left  = '0;
                    phase      = prdt_pkg::PH_HDR_LOW;
                    ticks_left = eff_len(timing.header_low_us);
                    frames_started++;
                end
            end
            else if (phase != prdt_pkg::PH_IDLE)
            begin
                step_tick();
            end
            s.line = (phase == prdt_pkg::PH_IDLE) || (phase == prdt_pkg::PH_HDR_HIGH) ||
                     (phase == prdt_pkg::PH_SPACE);
            s.busy = phase != prdt_pkg::PH_IDLE;
            expected_q.push_back(s);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= 20)
                $display("MISMATCH: %s", what);
        endtask

        task check_result(logic l, logic b, logic r);
            line_sample_t e;
            if (expected_q.size() == 0)
            begin
                report_mismatch("result arrived with nothing expected");
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (l !== e.line)
                report_mismatch($sformatf("result %0d: line_level %b, expected %b",
                                          checked, l, e.line));
            if (b !== e.busy)
                report_mismatch($sformatf("result %0d: busy_res %b, expected %b",
                                          checked, b, e.busy));
            if (r !== e.rejected)
                report_mismatch($sformatf("result %0d: start_rejected %b, expected %b",
                                          checked, r, e.rejected));
        endtask
    endclass

    logic                                clk            = 1'b0;
    logic                                rst_n          = 1'b0;
    logic                                in_valid       = 1'b0;
    logic                                in_ready;
    logic                                kind           = 1'b0;
    logic [7:0]                          first_byte     = '0;
    logic [7:0]                          second_byte    = '0;
    logic [prdt_pkg::LEN_W-1:0]          hold_ms        = '0;
    logic                                out_valid;
    logic                                out_ready      = 1'b0;
    logic                                line_level;
    logic                                busy_res;
    logic                                start_rejected;
    logic                                cfg_valid      = 1'b0;
    logic                                cfg_ready;
    logic [prdt_pkg::CFG_IDX_W-1:0]      cfg_index      = '0;
    logic [prdt_pkg::LEN_W-1:0]          cfg_data       = '0;

    tx_scoreboard board = new();
    int           items_sent  = 0;
    int           settings    = 0;
    int           idle_cycles = 0;

    pulse_distance_remote_transmitter uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .first_byte     (first_byte),
        .second_byte    (second_byte),
        .hold_ms        (hold_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .line_level     (line_level),
        .busy_res       (busy_res),
        .start_rejected (start_rejected),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(line_level, busy_res, start_rejected);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Receiver: random stalls, a stall-free stretch and long hold-offs that back up the input.
    initial
    begin
        int taken;
        int hold_off;
        int next_press;
        taken      = 0;
        hold_off   = 0;
        next_press = 200;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                taken++;
            if (hold_off > 0)
            begin
                hold_off--;
                out_ready <= 1'b0;
            end
            else if (taken >= next_press)
            begin
                hold_off   = PRESSURE_CYCLES;
                next_press = next_press + 20000;
                out_ready <= 1'b0;
            end
            else if (taken >= CALM_FIRST && taken < CALM_LAST)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= 6);
            end
        end
    end

    task automatic send_item(input logic k, input logic [7:0] fb, input logic [7:0] sb,
                             input logic [15:0] hm);
        int gap;
        gap = 0;
        if (!(items_sent >= CALM_FIRST && items_sent < CALM_LAST))
            while ($urandom_range(99) < 6)
                gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        first_byte  <= fb;
        second_byte <= sb;
        hold_ms     <= hm;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_item(k, fb, sb, hm);
        items_sent++;
    endtask

    // Tick until the frame ends; optionally slip in a refused start after some ticks.
    task automatic run_frame(input int reject_at);
        int n;
        n = 0;
        while (board.frame_active())
        begin
            if (n == reject_at)
                send_item(1'b1, 8'($urandom), 8'($urandom), 16'($urandom));
            else
                send_item(1'b0, 8'($urandom), 8'($urandom), 16'($urandom));
            n++;
        end
    endtask

    // Random ticks and refused starts until the frame ends.
    task automatic run_random_frame();
        while (board.frame_active())
            send_item(($urandom_range(99) < 5), 8'($urandom), 8'($urandom),
                      16'($urandom));
    endtask

    task automatic cfg_write(input logic [prdt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [prdt_pkg::LEN_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_reg(idx, data);
    endtask

    // Finish the frame, drain results, then load a new timing set.
    task automatic program_timing(input logic [15:0] hl, input logic [15:0] hh,
                                  input logic [15:0] mk, input logic [15:0] s0,
                                  input logic [15:0] s1, input bit poke_unused);
        int i;
        run_frame(-1);
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        cfg_write(prdt_pkg::REG_HEADER_LOW, hl);
        cfg_write(prdt_pkg::REG_HEADER_HIGH, hh);
        cfg_write(prdt_pkg::REG_MARK, mk);
        cfg_write(prdt_pkg::REG_SPACE_ZERO, s0);
        cfg_write(prdt_pkg::REG_SPACE_ONE, s1);
        if (poke_unused)
            for (i = int'(prdt_pkg::REG_SPACE_ONE) + 1; i < 2 ** prdt_pkg::CFG_IDX_W; i++)
                cfg_write(prdt_pkg::CFG_IDX_W'(i), 16'hFFFF);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    function automatic logic [15:0] short_len();
        return 16'($urandom_range(0, 4));
    endfunction

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset timing: idle ticks with junk payloads change nothing.
        send_item(1'b0, 8'hFF, 8'hFF, 16'hFFFF);
        send_item(1'b0, 8'h00, 8'h00, 16'h0000);

        // Short timing; out-of-range register writes must be dropped.
        program_timing(16'd3, 16'd2, 16'd1, 16'd1, 16'd2, 1'b1);
        send_item(1'b1, 8'h00, 8'hFF, 16'h0000);
        send_item(1'b1, 8'h0F, 8'hF0, 16'hFFFF);
        run_frame(5);
        send_item(1'b0, 8'hAA, 8'h55, 16'hAAAA);

        // All-zero lengths behave as one tick each.
        program_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_item(1'b1, 8'h3C, 8'hC3, 16'h0000);
        run_frame(7);

        // Random short timing, then a one-millisecond hold with refused starts in it.
        program_timing(short_len(), short_len(), short_len(), short_len(),
                       short_len(), 1'b0);
        send_item(1'b1, 8'hA5, 8'h5A, 16'd1);
        run_random_frame();
        send_item(1'b0, 8'h5A, 8'hA5, 16'h0002);

        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (board.pending() != 0)
            board.report_mismatch("expected results left over at the end");
        $display("Sent %0d items over %0d timing sets: %0d frames, %0d starts refused",
                 items_sent, settings + 1, board.frames_started, board.starts_rejected);
        $display("Checked %0d results, %0d mismatches", board.checked, board.mismatches);
        if (board.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
